// ----- rtl/masked_byte_pattern_scan_macros.svh -----
// assertion macros used by masked_byte_pattern_scan.sv
`ifndef MASKED_BYTE_PATTERN_SCAN_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCAN_MACROS_SVH

`ifndef SYNTHESIS

`define MBPS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define MBPS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define MBPS_ASSERT(lbl, clk, rst_n, prop)
`define MBPS_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- rtl/mbps_pkg.sv -----
`default_nettype none

package mbps_pkg;

	localparam int PAT_BYTES  = 16;
	localparam int PAT_IDX_W  = 4;
	localparam int ADDR_W     = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int CARE_W     = 16;
	localparam int PLEN_W     = 5;
	localparam int STRIDE_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 3'd5;

	typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/mbps_cell.sv -----
`default_nettype none

module mbps_cell #(
	parameter int IDX   = 0,
	parameter int LEN_W = 5
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  mbps_pkg::cell_ctrl_t    ctrl,
	input  wire  [7:0]              din,
	input  wire  [LEN_W-1:0]        len,
	input  mbps_pkg::pat_bytes_t    pattern,
	input  wire  [mbps_pkg::CARE_W-1:0] care,
	output logic [7:0]              dout,
	output logic                    ok
);
	import mbps_pkg::*;

	localparam int JW = (LEN_W > PAT_IDX_W + 1) ? LEN_W : PAT_IDX_W + 1;

	logic [7:0]    win_q;
	logic [JW-1:0] j;
	logic          active;
	logic          in_pat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctrl.clear) begin
			win_q <= '0;
		end else if (ctrl.shift) begin
			win_q <= din;
		end
	end

	// this cell checks window byte IDX (counted back from the newest), aligned with pattern byte len-1-IDX
	always_comb begin
		j      = JW'(len) - JW'(1) - JW'(IDX);
		active = JW'(IDX) < JW'(len);
		in_pat = j < JW'(PAT_BYTES);
		ok     = !active || !in_pat || !care[j[PAT_IDX_W-1:0]] ||
			(pattern[j[PAT_IDX_W-1:0]] == din);
	end

	assign dout = win_q;

endmodule

`default_nettype wire

// ----- rtl/mbps_out_buf.sv -----
`default_nettype none

module mbps_out_buf (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  mbps_pkg::result_t  din,
	output logic               room,
	output logic               out_valid,
	input  wire                out_ready,
	output mbps_pkg::result_t  dout
);
	import mbps_pkg::*;

	logic    main_v_q;
	logic    skid_v_q;
	result_t main_q;
	result_t skid_q;
	logic    out_fire;

	assign out_fire  = main_v_q && out_ready;
	assign room      = !skid_v_q;
	assign out_valid = main_v_q;
	assign dout      = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!main_v_q) begin
				main_v_q <= push;
			end else if (out_fire) begin
				main_v_q <= skid_v_q || push;
				skid_v_q <= skid_v_q && push;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q) begin
			if (push) begin
				main_q <= din;
			end
		end else if (out_fire) begin
			if (skid_v_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= din;
				end
			end else if (push) begin
				main_q <= din;
			end
		end else if (push) begin
			skid_q <= din;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/masked_byte_pattern_scan.sv -----
// the result of an accepted beat is registered in the output buffer before it appears on out_valid
// throughput: one byte per cycle while in_ready is high, the masked compare runs across the cell row in parallel
// the two-entry output buffer keeps in_ready high while one result waits
// reset: asynchronous, clears window, counters, buffer and registers (length and stride to 1)
`default_nettype none

`include "masked_byte_pattern_scan_macros.svh"

module masked_byte_pattern_scan #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_write,
	input  wire  [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [7:0]                      data_byte,
	input  wire                             last_byte,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic                            found,
	output logic [mbps_pkg::ADDR_W-1:0]     match_address
);
	import mbps_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int POS_W = OFFSET_BITS + 1;

	logic [63:0]          pattern_low_q;
	logic [63:0]          pattern_high_q;
	logic [CARE_W-1:0]    care_mask_q;
	logic [PLEN_W-1:0]    pattern_length_q;
	logic [STRIDE_W-1:0]  stride_q;
	logic [ADDR_W-1:0]    base_address_q;

	logic [OFFSET_BITS-1:0] pos_q;
	logic [STRIDE_W-1:0]    phase_q;
	logic                   reported_q;

	logic [LEN_W-1:0]       len;
	logic [STRIDE_W-1:0]    st;
	pat_bytes_t             pattern;
	cell_ctrl_t             cell_ctrl;
	logic [MAX_PATTERN-1:0][7:0] cell_in;
	logic [MAX_PATTERN-1:0][7:0] cell_out;
	logic [MAX_PATTERN-1:0] cell_ok;
	logic                   win_ok;

	logic                   in_fire;
	logic                   pos_sat;
	logic [POS_W-1:0]       pos_inc;
	logic [POS_W-1:0]       offset;
	logic                   try_win;
	logic                   match;
	logic [STRIDE_W:0]      phase_inc;
	logic [STRIDE_W-1:0]    phase_nxt;
	logic                   push;
	logic                   room;
	result_t                res;
	result_t                res_out;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			care_mask_q      <= '0;
			pattern_length_q <= PLEN_W'(1);
			stride_q         <= STRIDE_W'(1);
			base_address_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data[63:0];
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data[63:0];
				REG_CARE_MASK:      care_mask_q      <= cfg_data[CARE_W-1:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[PLEN_W-1:0];
				REG_STRIDE:         stride_q         <= cfg_data[STRIDE_W-1:0];
				REG_BASE_ADDRESS:   base_address_q   <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pattern_length_q == '0) begin
			len = LEN_W'(1);
		end else if (int'(pattern_length_q) > MAX_PATTERN) begin
			len = LEN_W'(MAX_PATTERN);
		end else begin
			len = LEN_W'(pattern_length_q);
		end
		st = (stride_q == '0) ? STRIDE_W'(1) : stride_q;
	end

	assign pattern = pat_bytes_t'({pattern_high_q, pattern_low_q});

	// cell row
	assign cell_in[0] = data_byte;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		if (k > 0) begin : g_link
			assign cell_in[k] = cell_out[k-1];
		end
		mbps_cell #(
			.IDX   (k),
			.LEN_W (LEN_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cell_ctrl),
			.din     (cell_in[k]),
			.len     (len),
			.pattern (pattern),
			.care    (care_mask_q),
			.dout    (cell_out[k]),
			.ok      (cell_ok[k])
		);
	end

	assign win_ok = &cell_ok;

	// scan control
	always_comb begin
		in_fire         = in_valid && in_ready;
		pos_sat         = &pos_q;
		pos_inc         = {1'b0, pos_q} + POS_W'(1);
		try_win         = !pos_sat && (pos_inc >= POS_W'(len));
		match           = try_win && !last_byte && (phase_q == '0) && win_ok;
		phase_inc       = {1'b0, phase_q} + (STRIDE_W+1)'(1);
		phase_nxt       = (phase_inc >= {1'b0, st}) ? '0 : phase_inc[STRIDE_W-1:0];
		cell_ctrl.shift = in_fire && !reported_q && !last_byte;
		cell_ctrl.clear = in_fire && last_byte;
		push            = in_fire && !reported_q && (match || last_byte);
		offset          = pos_inc - POS_W'(len);
		res.found       = match;
		res.addr        = match ? (base_address_q + ADDR_W'(offset)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			phase_q    <= '0;
			reported_q <= 1'b0;
		end else if (in_fire) begin
			if (last_byte) begin
				pos_q      <= '0;
				phase_q    <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				if (try_win) begin
					phase_q <= phase_nxt;
				end
				if (!pos_sat) begin
					pos_q <= pos_inc[OFFSET_BITS-1:0];
				end
				reported_q <= match;
			end
		end
	end

	mbps_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (res_out)
	);

	assign in_ready      = room;
	assign found         = res_out.found;
	assign match_address = res_out.addr;

	`MBPS_ASSERT(a_miss_addr_zero, clk, arst_n, out_valid && !found |-> match_address == '0)
	`MBPS_ASSERT(a_match_sets_reported, clk, arst_n, push && match |=> reported_q)
	`MBPS_ASSERT(a_last_clears, clk, arst_n, in_fire && last_byte |=> pos_q == '0 && phase_q == '0 && !reported_q)
	`MBPS_ASSERT_NEVER(a_no_push_after_report, clk, arst_n, reported_q && push)

endmodule

`default_nettype wire
